// ----- rtl/adpp_pkg.sv -----
`default_nettype none

package adpp_pkg;

  // Number format and limits
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned MAX_FIELDS       = 8;
  localparam int unsigned MAX_PACKET_BYTES = 256;
  localparam int unsigned MIN_TOKENS       = 2;
  localparam int unsigned MAX_FRAC_DIGITS  = 5;
  // Ten to the power of MAX_FRAC_DIGITS.
  localparam int unsigned FRAC_SCALE       = 100000;

  // Integer magnitude saturates at 2^(32-FRAC_BITS), so it needs one bit more.
  localparam int unsigned INT_W       = 32 - FRAC_BITS + 1;
  localparam int unsigned FRAC_ACC_W  = 17;
  localparam int unsigned DIGIT_CNT_W = 3;
  localparam int unsigned PLEN_W      = $clog2(MAX_PACKET_BYTES);
  localparam int unsigned FIELD_AW    = $clog2(MAX_FIELDS);
  localparam int unsigned CNT_W       = $clog2(MAX_FIELDS + 1);

  localparam logic [INT_W-1:0] INT_CAP = {1'b1, {(INT_W - 1){1'b0}}};

  localparam logic [7:0] SEP_RESET  = 8'd44;
  localparam logic [7:0] BYTE_D     = 8'h64;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_VT    = 8'h0B;
  localparam logic [7:0] BYTE_FF    = 8'h0C;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_PLUS  = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_DOT   = 8'h2E;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  // One entry of the queue between the byte parser and the value unit.
  typedef struct packed {
    logic                   tok;      // a token closed on this beat
    logic                   pkt_end;  // packet terminator
    logic                   drop;     // partial packet discarded
    logic                   neg;
    logic [INT_W-1:0]       int_acc;
    logic [FRAC_ACC_W-1:0]  frac_acc;
    logic [DIGIT_CNT_W-1:0] digits;
  } token_rec_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } back_status_t;

  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [DIGIT_CNT_W-1:0] n);
    logic [FRAC_ACC_W-1:0] p;
    unique case (n)
      3'd0:    p = FRAC_ACC_W'(1);
      3'd1:    p = FRAC_ACC_W'(10);
      3'd2:    p = FRAC_ACC_W'(100);
      3'd3:    p = FRAC_ACC_W'(1000);
      3'd4:    p = FRAC_ACC_W'(10000);
      default: p = FRAC_ACC_W'(100000);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/adpp_fifo.sv -----
`default_nettype none

module adpp_fifo
  import adpp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire token_rec_t in_rec_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output token_rec_t      out_rec_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  token_rec_t          mem_q [DEPTH];
  logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [AW:0]         fill_q, fill_d;
  logic                push, pop;

  assign in_ready_o  = (fill_q != (AW + 1)'(DEPTH));
  assign out_valid_o = (fill_q != '0);
  assign out_rec_o   = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + (AW + 1)'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_rec_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/adpp_front.sv -----
`default_nettype none

module adpp_front
  import adpp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] separator_i,
  input  wire logic       byte_valid_i,
  output logic            byte_ready_o,
  input  wire logic [7:0] byte_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output token_rec_t      push_rec_o
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  localparam int unsigned INT_MW = INT_W + 4;

  logic [INT_W-1:0]       int_q, int_d;
  logic [FRAC_ACC_W-1:0]  frac_q, frac_d;
  logic [DIGIT_CNT_W-1:0] digits_q, digits_d;
  logic                   neg_q, neg_d;
  logic                   open_q, open_d;
  logic [1:0]             phase_q, phase_d;
  logic [PLEN_W-1:0]      plen_q, plen_d;

  logic              fire, need_push;
  logic              is_term, is_digit, is_space;
  logic [3:0]        dval;
  logic [INT_MW-1:0] int_next;

  // Every beat may push one entry, so a byte is taken only while the queue has room.
  assign byte_ready_o = push_ready_i;
  assign fire         = byte_valid_i && byte_ready_o;
  assign push_valid_o = fire && need_push;

  assign is_term  = (byte_i == BYTE_D) || (byte_i == BYTE_NL);
  assign is_digit = (byte_i >= BYTE_ZERO) && (byte_i <= BYTE_NINE);
  assign is_space = (byte_i == BYTE_SPACE) || (byte_i == BYTE_TAB) || (byte_i == BYTE_VT) ||
                    (byte_i == BYTE_FF) || (byte_i == BYTE_CR);
  assign dval     = byte_i[3:0];
  assign int_next = (INT_MW'(int_q) << 3) + (INT_MW'(int_q) << 1) + INT_MW'(dval);

  always_comb begin
    int_d     = int_q;
    frac_d    = frac_q;
    digits_d  = digits_q;
    neg_d     = neg_q;
    open_d    = open_q;
    phase_d   = phase_q;
    plen_d    = plen_q;
    need_push = 1'b0;

    push_rec_o          = '0;
    push_rec_o.neg      = neg_q;
    push_rec_o.int_acc  = int_q;
    push_rec_o.frac_acc = frac_q;
    push_rec_o.digits   = digits_q;

    if (is_term) begin
      need_push          = 1'b1;
      push_rec_o.tok     = open_q;
      push_rec_o.pkt_end = 1'b1;
      plen_d             = '0;
    end else if (plen_q == PLEN_W'(MAX_PACKET_BYTES - 1)) begin
      need_push       = 1'b1;
      push_rec_o.drop = 1'b1;
      plen_d          = '0;
    end else begin
      plen_d = plen_q + PLEN_W'(1);
      if (byte_i == separator_i) begin
        need_push      = open_q;
        push_rec_o.tok = open_q;
      end else begin
        open_d = 1'b1;
        if (phase_q != PH_STOP) begin
          if (is_digit) begin
            if (phase_q == PH_FRAC) begin
              if (digits_q < DIGIT_CNT_W'(MAX_FRAC_DIGITS)) begin
                frac_d   = FRAC_ACC_W'((frac_q << 3) + (frac_q << 1) + FRAC_ACC_W'(dval));
                digits_d = digits_q + DIGIT_CNT_W'(1);
              end
            end else begin
              int_d   = (int_next > INT_MW'(INT_CAP)) ? INT_CAP : int_next[INT_W-1:0];
              phase_d = PH_INT;
            end
          end else if (phase_q == PH_LEAD && is_space) begin
            phase_d = PH_LEAD;
          end else if (phase_q == PH_LEAD &&
                       (byte_i == BYTE_PLUS || byte_i == BYTE_MINUS)) begin
            neg_d   = (byte_i == BYTE_MINUS);
            phase_d = PH_INT;
          end else if (byte_i == BYTE_DOT && (phase_q == PH_LEAD || phase_q == PH_INT)) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
      end
    end

    // Anything but a parsed byte leaves the parser between tokens.
    if (is_term || need_push || (byte_i == separator_i)) begin
      if (!(plen_q != PLEN_W'(MAX_PACKET_BYTES - 1) && !is_term && byte_i != separator_i)) begin
        int_d    = '0;
        frac_d   = '0;
        digits_d = '0;
        neg_d    = 1'b0;
        open_d   = 1'b0;
        phase_d  = PH_LEAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q    <= '0;
      frac_q   <= '0;
      digits_q <= '0;
      neg_q    <= 1'b0;
      open_q   <= 1'b0;
      phase_q  <= PH_LEAD;
      plen_q   <= '0;
    end else if (fire) begin
      int_q    <= int_d;
      frac_q   <= frac_d;
      digits_q <= digits_d;
      neg_q    <= neg_d;
      open_q   <= open_d;
      phase_q  <= phase_d;
      plen_q   <= plen_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/adpp_back.sv -----
`default_nettype none

module adpp_back
  import adpp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rec_valid_i,
  output logic            rec_ready_o,
  input  wire token_rec_t rec_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [31:0]     out_value_o,
  output logic [2:0]      out_index_o,
  output logic            out_last_o,
  output back_status_t    status_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Rounded fraction ((frac << FRAC_BITS) + p/2) / p with p = 10^digits. The fraction is
  // first scaled to the full digit count, so the divisor is always FRAC_SCALE = 32 * 3125.
  // The power of two drops out as a shift and 3125 is done by a reciprocal multiply,
  // exact for every scaled numerator below 2^M_W.
  localparam int unsigned LOW_W   = FRAC_BITS - MAX_FRAC_DIGITS;
  localparam int unsigned ODD_DIV = FRAC_SCALE >> MAX_FRAC_DIGITS;
  localparam int unsigned ODD_L   = $clog2(ODD_DIV);
  localparam int unsigned M_W     = FRAC_ACC_W + LOW_W;
  localparam int unsigned RCP_W   = M_W + 1;
  localparam int unsigned PROD_W  = M_W + RCP_W;
  localparam int unsigned RCP_SH  = M_W + ODD_L;
  localparam int unsigned MAG_W   = INT_W + FRAC_BITS + 1;

  localparam logic [RCP_W-1:0] RECIP    =
    RCP_W'(((64'd1 << RCP_SH) / 64'(ODD_DIV)) + 64'd1);
  localparam logic [M_W-1:0]   HALF_LSB = M_W'((FRAC_SCALE / 2) >> MAX_FRAC_DIGITS);

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [FIELD_AW-1:0]    k_q, k_d;
  logic                   end_q;
  logic                   neg_q;
  logic [INT_W-1:0]       int_q;
  logic [FRAC_ACC_W-1:0]  frac5_q;
  logic [PROD_W-1:0]      prod_q;
  logic [MAG_W-1:0]       mag_q;
  logic [31:0]            store_q [MAX_FIELDS];
  logic [31:0]            rd_data_q;

  logic [DIGIT_CNT_W-1:0] scale_sel;
  logic [FRAC_ACC_W-1:0]  frac5;
  logic [M_W-1:0]         m_val;
  logic [31:0]            sat_value;
  logic                   store_we;

  assign rec_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_value_o = rd_data_q;
  assign out_index_o = 3'(k_q);
  assign out_last_o  = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

  assign status_o.idle  = (state_q == S_IDLE);
  assign status_o.count = count_q;

  assign scale_sel = (rec_i.digits >= DIGIT_CNT_W'(MAX_FRAC_DIGITS)) ? '0 :
                     (DIGIT_CNT_W'(MAX_FRAC_DIGITS) - rec_i.digits);
  // The scaled fraction stays below FRAC_SCALE, so the low bits hold all of it.
  assign frac5     = FRAC_ACC_W'(rec_i.frac_acc * pow10(scale_sel));
  assign m_val     = (M_W'(frac5_q) << LOW_W) + HALF_LSB;
  assign store_we  = (state_q == S_WRITE) && (count_q < CNT_W'(MAX_FIELDS));

  always_comb begin
    if (neg_q) begin
      sat_value = (mag_q >= MAG_W'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - mag_q[31:0]);
    end else begin
      sat_value = (mag_q > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag_q[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (rec_valid_i) begin
          if (rec_i.drop) begin
            count_d = '0;
          end else if (rec_i.tok) begin
            state_d = S_MUL;
          end else if (rec_i.pkt_end) begin
            state_d = S_END;
          end
        end
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (count_q < CNT_W'(MAX_FIELDS)) begin
          count_d = count_q + CNT_W'(1);
        end
        state_d = end_q ? S_END : S_IDLE;
      end
      S_END: begin
        k_d = '0;
        if (count_q >= CNT_W'(MIN_TOKENS)) begin
          state_d = S_RD;
        end else begin
          count_d = '0;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (out_last_o) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + FIELD_AW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && rec_valid_i) begin
      end_q   <= rec_i.pkt_end;
      neg_q   <= rec_i.neg;
      int_q   <= rec_i.int_acc;
      frac5_q <= frac5;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(m_val) * PROD_W'(RECIP);
    end
    if (state_q == S_SUM) begin
      mag_q <= (MAG_W'(int_q) << FRAC_BITS) + MAG_W'(prod_q[PROD_W-1:RCP_SH]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[FIELD_AW-1:0]] <= sat_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_data_q <= store_q[k_q];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ascii_decimal_packet_parser.sv -----
`default_nettype none

// Channel    Direction  Beat contents
// s_axis     in         tdata[7:0] = data_byte
// m_axis     out        tdata[31:0] = field_value, tuser[2:0] = field_index, tlast = last
// APB        in/out     byte address 0 = separator (bits 7:0)
//
// A byte is taken in every cycle while the four-entry token queue has room.
// Each closed token takes the value unit through pop with fraction scaling, reciprocal
// multiply, sum and store write; a terminator adds an end check, and each emitted
// field is a store read, then the output register.
// Reset clears all control state and sets the separator to ','.
// A stalled output holds the value unit; the byte side keeps running until the queue fills.

module ascii_decimal_packet_parser
  import adpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] field_value
  output logic [2:0]       m_axis_tuser,   // [2:0] field_index
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_SEPARATOR = 1'b0;

  logic [7:0]   sep_q;
  logic         push_valid, push_ready;
  token_rec_t   push_rec;
  logic         rec_valid, rec_ready;
  token_rec_t   rec;
  back_status_t bk_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEPARATOR) ? {24'd0, sep_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEPARATOR) begin
      sep_q <= pwdata[7:0];
    end
  end

  adpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .separator_i  (sep_q),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  adpp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_rec_i    (push_rec),
    .out_valid_o (rec_valid),
    .out_ready_i (rec_ready),
    .out_rec_o   (rec)
  );

  adpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .rec_i       (rec),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_index_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .status_o    (bk_status)
  );

  // A queue entry is never offered while the queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("token queue written while full");

  // Fields go out only for packets with at least two tokens.
  a_min_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (bk_status.count >= CNT_W'(MIN_TOKENS)))
    else $error("field emitted for a short packet");

  // After a beat that is not the last, valid drops for the store read while the value unit stays busy.
  a_beat_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!m_axis_tvalid && !bk_status.idle))
    else $error("packet drain broken off early");

  // The last beat of a packet returns the value unit to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      (bk_status.idle && bk_status.count == '0))
    else $error("value unit not idle after last beat");

endmodule

`default_nettype wire
